/* hw/rtl/hgcd_pkg.sv */
// ----------------------------------------------------------------------------
// hgcd_pkg
// Shared constants and arithmetic helpers for the great-circle distance block.
// ----------------------------------------------------------------------------
package hgcd_pkg;

  localparam int unsigned RAD_W    = 33;  // signed Q.30 angle of one coordinate
  localparam int unsigned SC_W     = 34;  // signed sine/cosine and products
  localparam int unsigned ROOT_W   = 31;  // Q.30 values in [0, 1]
  localparam int unsigned ANG_W    = 31;  // central angle, unsigned Q.30
  localparam int unsigned RADIUS_W = 23;
  localparam int unsigned DIST_W   = 35;
  localparam int unsigned SQRT_STAGES = 31;
  localparam int unsigned ATAN_ENTRIES = 40;

  localparam logic [30:0] DEG_TO_RAD_K = 31'd2012227627;
  localparam logic [31:0] PI_Q30       = 32'd3373259426;
  localparam logic [31:0] HALF_PI_Q30  = 32'd1686629713;
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
  localparam logic [30:0] ONE_Q30      = 31'd1073741824;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6371001;

  // arctangent of 2^-i in Q.30
  function automatic logic [29:0] atan_q30(input int unsigned i);
    logic [29:0] v;
    unique case (i)
      0:  v = 30'd843314857;
      1:  v = 30'd497837829;
      2:  v = 30'd263043837;
      3:  v = 30'd133525159;
      4:  v = 30'd67021687;
      5:  v = 30'd33543516;
      6:  v = 30'd16775851;
      7:  v = 30'd8388437;
      8:  v = 30'd4194283;
      9:  v = 30'd2097149;
      10: v = 30'd1048576;
      11: v = 30'd524288;
      12: v = 30'd262144;
      13: v = 30'd131072;
      14: v = 30'd65536;
      15: v = 30'd32768;
      16: v = 30'd16384;
      17: v = 30'd8192;
      18: v = 30'd4096;
      19: v = 30'd2048;
      20: v = 30'd1024;
      21: v = 30'd512;
      22: v = 30'd256;
      23: v = 30'd128;
      24: v = 30'd64;
      25: v = 30'd32;
      26: v = 30'd16;
      27: v = 30'd8;
      28: v = 30'd4;
      29: v = 30'd2;
      30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // 1e-7 degree to Q.30 radians, rounded half up on the magnitude
  function automatic logic signed [RAD_W-1:0] to_rad(input logic signed [31:0] d);
    logic [31:0] mag;
    logic [63:0] prod;
    logic [RAD_W-1:0] r;
    mag  = d[31] ? (~d + 32'd1) : d;
    prod = 64'(mag) * 64'(DEG_TO_RAD_K) + (64'd1 << 29);
    r    = {1'b0, prod[61:30]};
    return d[31] ? signed'(-r) : signed'(r);
  endfunction

  // Q.30 product, magnitude rounded half up
  function automatic logic signed [SC_W-1:0] mul_q30(input logic signed [SC_W-1:0] p,
                                                     input logic signed [SC_W-1:0] q);
    logic [SC_W-1:0] mp;
    logic [SC_W-1:0] mq;
    logic [2*SC_W-1:0] pr;
    logic [SC_W-1:0] r;
    mp = p[SC_W-1] ? SC_W'(-p) : SC_W'(p);
    mq = q[SC_W-1] ? SC_W'(-q) : SC_W'(q);
    pr = (2*SC_W)'(mp) * (2*SC_W)'(mq) + ((2*SC_W)'(1) << 29);
    r  = pr[SC_W+29:30];
    return (p[SC_W-1] != q[SC_W-1]) ? signed'(-r) : signed'(r);
  endfunction

endpackage

/* hw/rtl/hgcd_rot_cordic.sv */
// ----------------------------------------------------------------------------
// hgcd_rot_cordic
// Pipelined rotation CORDIC: quadrant fold, one step per stage, sign fixup.
// ----------------------------------------------------------------------------
module hgcd_rot_cordic #(
  parameter int unsigned STEPS = 28
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [hgcd_pkg::RAD_W-1:0]   in_ang,
  output logic                                out_valid,
  output logic signed [hgcd_pkg::SC_W-1:0]    out_sin,
  output logic signed [hgcd_pkg::SC_W-1:0]    out_cos
);
  import hgcd_pkg::*;

  localparam int unsigned Z_W = 36;

  logic signed [SC_W-1:0] x_r [0:STEPS];
  logic signed [SC_W-1:0] y_r [0:STEPS];
  logic signed [Z_W-1:0]  z_r [0:STEPS];
  logic                   neg_r  [0:STEPS];
  logic                   flip_r [0:STEPS];
  logic                   vld_r  [0:STEPS];

  logic [RAD_W:0]         mag;
  logic                   fold;
  logic signed [Z_W-1:0]  z_nxt;

  assign mag   = in_ang[RAD_W-1] ? (RAD_W+1)'(-in_ang) : (RAD_W+1)'(in_ang);
  assign fold  = mag > (RAD_W+1)'(HALF_PI_Q30);
  assign z_nxt = fold ? signed'(Z_W'(PI_Q30) - Z_W'(mag)) : signed'(Z_W'(mag));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= signed'(SC_W'(INV_GAIN_Q30));
      y_r[0]    <= '0;
      z_r[0]    <= z_nxt;
      neg_r[0]  <= in_ang[RAD_W-1];
      flip_r[0] <= fold;
    end
  end

  for (genvar i = 1; i <= STEPS; i++) begin : g_step
    logic signed [SC_W-1:0] dx;
    logic signed [SC_W-1:0] dy;
    logic signed [Z_W-1:0]  at;
    assign dx = y_r[i-1] >>> (i-1);
    assign dy = x_r[i-1] >>> (i-1);
    assign at = signed'(Z_W'(atan_q30(i-1)));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (z_r[i-1] >= 0) begin
          x_r[i] <= x_r[i-1] - dx;
          y_r[i] <= y_r[i-1] + dy;
          z_r[i] <= z_r[i-1] - at;
        end else begin
          x_r[i] <= x_r[i-1] + dx;
          y_r[i] <= y_r[i-1] - dy;
          z_r[i] <= z_r[i-1] + at;
        end
        neg_r[i]  <= neg_r[i-1];
        flip_r[i] <= flip_r[i-1];
      end
    end
  end

  logic                   out_valid_r;
  logic signed [SC_W-1:0] sin_r;
  logic signed [SC_W-1:0] cos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= neg_r[STEPS]  ? -y_r[STEPS] : y_r[STEPS];
      cos_r <= flip_r[STEPS] ? -x_r[STEPS] : x_r[STEPS];
    end
  end

  assign out_valid = out_valid_r;
  assign out_sin   = sin_r;
  assign out_cos   = cos_r;

endmodule

/* hw/rtl/hgcd_sqrt.sv */
// ----------------------------------------------------------------------------
// hgcd_sqrt
// Pipelined bit-by-bit square root of a Q.30 value, one root bit per stage.
// ----------------------------------------------------------------------------
module hgcd_sqrt (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [hgcd_pkg::ROOT_W-1:0]        in_val,
  output logic                               out_valid,
  output logic [hgcd_pkg::ROOT_W-1:0]        out_root
);
  import hgcd_pkg::*;

  localparam int unsigned V_W = 62;

  logic [V_W-1:0] v_r [0:SQRT_STAGES-1];
  logic [V_W-1:0] r_r [0:SQRT_STAGES-1];
  logic           vld_r [0:SQRT_STAGES-1];

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
    localparam int unsigned K = SQRT_STAGES - 1 - j;
    logic [V_W-1:0] v_in;
    logic [V_W-1:0] r_in;
    logic [V_W-1:0] trial;
    logic           vld_in;
    logic [V_W-1:0] bitv;

    if (j == 0) begin : g_first
      assign v_in   = {1'b0, in_val, 30'd0};
      assign r_in   = '0;
      assign vld_in = in_valid;
    end else begin : g_next
      assign v_in   = v_r[j-1];
      assign r_in   = r_r[j-1];
      assign vld_in = vld_r[j-1];
    end

    assign bitv  = V_W'(1) << (2*K);
    assign trial = r_in + bitv;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (v_in >= trial) begin
          v_r[j] <= v_in - trial;
          r_r[j] <= (r_in >> 1) + bitv;
        end else begin
          v_r[j] <= v_in;
          r_r[j] <= r_in >> 1;
        end
      end
    end
  end

  assign out_valid = vld_r[SQRT_STAGES-1];
  assign out_root  = r_r[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

/* hw/rtl/hgcd_vec_cordic.sv */
// ----------------------------------------------------------------------------
// hgcd_vec_cordic
// Pipelined vectoring CORDIC: angle of (x, y), negative result taken as zero.
// ----------------------------------------------------------------------------
module hgcd_vec_cordic #(
  parameter int unsigned STEPS = 28
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [hgcd_pkg::ROOT_W-1:0]      in_x,
  input  logic [hgcd_pkg::ROOT_W-1:0]      in_y,
  output logic                             out_valid,
  output logic [hgcd_pkg::ANG_W-1:0]       out_ang
);
  import hgcd_pkg::*;

  localparam int unsigned Z_W = 34;

  logic signed [SC_W-1:0] x_r [0:STEPS-1];
  logic signed [SC_W-1:0] y_r [0:STEPS-1];
  logic signed [Z_W-1:0]  z_r [0:STEPS-1];
  logic                   vld_r [0:STEPS-1];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [SC_W-1:0] x_in;
    logic signed [SC_W-1:0] y_in;
    logic signed [Z_W-1:0]  z_in;
    logic                   vld_in;
    logic signed [SC_W-1:0] dx;
    logic signed [SC_W-1:0] dy;
    logic signed [Z_W-1:0]  at;

    if (i == 0) begin : g_first
      assign x_in   = signed'(SC_W'(in_x));
      assign y_in   = signed'(SC_W'(in_y));
      assign z_in   = '0;
      assign vld_in = in_valid;
    end else begin : g_next
      assign x_in   = x_r[i-1];
      assign y_in   = y_r[i-1];
      assign z_in   = z_r[i-1];
      assign vld_in = vld_r[i-1];
    end

    assign dx = y_in >>> i;
    assign dy = x_in >>> i;
    assign at = signed'(Z_W'(atan_q30(i)));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (y_in >= 0) begin
          x_r[i] <= x_in + dx;
          y_r[i] <= y_in - dy;
          z_r[i] <= z_in + at;
        end else begin
          x_r[i] <= x_in - dx;
          y_r[i] <= y_in + dy;
          z_r[i] <= z_in - at;
        end
      end
    end
  end

  logic             out_valid_r;
  logic [ANG_W-1:0] ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r <= (z_r[STEPS-1] < 0) ? '0 : z_r[STEPS-1][ANG_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_ang   = ang_r;

endmodule

/* hw/rtl/haversine_great_circle_distance_top.sv */
// ----------------------------------------------------------------------------
// haversine_great_circle_distance_top
// Great-circle distance in millimeters between two lat/lon points.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one item: two points in 1e-7 degree.
// Output channel (out_valid/out_ready) returns one distance per item, in order.
// Config channel (cfg_valid/cfg_ready) writes the sphere radius in meters;
// it is always ready and should only be written while the pipeline is empty.
// Throughput: one item per cycle unless out_ready stalls the pipeline.
// The path runs through two CORDIC pipelines in series (one step per stage)
// and the 31-stage square root, one root bit per stage.
// The whole pipeline advances on one enable; when the receiver holds
// out_ready low with a result waiting, every stage holds and in_ready drops,
// so nothing is lost or repeated.
// Reset clears all valid bits and loads the radius with 6371001 m.
// ----------------------------------------------------------------------------
module haversine_great_circle_distance_top #(
  parameter int unsigned CORDIC_STEPS = 28
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [hgcd_pkg::RADIUS_W-1:0]        cfg_earth_radius_m,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [30:0]                   in_lat_a,
  input  logic signed [31:0]                   in_lon_a,
  input  logic signed [30:0]                   in_lat_b,
  input  logic signed [31:0]                   in_lon_b,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [hgcd_pkg::DIST_W-1:0]          out_distance_mm
);
  import hgcd_pkg::*;

  logic en;
  logic [RADIUS_W-1:0] radius_r;

  logic out_valid_r;
  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_valid) begin
      radius_r <= cfg_earth_radius_m;
    end
  end

  // stage: radians
  logic                    rad_vld_r;
  logic signed [RAD_W-1:0] la_r, oa_r, lb_r, ob_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad_vld_r <= 1'b0;
    end else if (en) begin
      rad_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      la_r <= to_rad(32'(in_lat_a));
      oa_r <= to_rad(in_lon_a);
      lb_r <= to_rad(32'(in_lat_b));
      ob_r <= to_rad(in_lon_b);
    end
  end

  // stage: half differences (floor shift drops the lsb)
  logic                    half_vld_r;
  logic signed [RAD_W-1:0] hlat_ang_r, hlon_ang_r, la2_r, lb2_r;
  logic signed [RAD_W:0]   dlat, dlon;

  assign dlat = (RAD_W+1)'(lb_r) - (RAD_W+1)'(la_r);
  assign dlon = (RAD_W+1)'(ob_r) - (RAD_W+1)'(oa_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_vld_r <= 1'b0;
    end else if (en) begin
      half_vld_r <= rad_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hlat_ang_r <= dlat[RAD_W:1];
      hlon_ang_r <= dlon[RAD_W:1];
      la2_r      <= la_r;
      lb2_r      <= lb_r;
    end
  end

  // four sine/cosine pipelines of equal latency
  logic                   sc_vld;
  logic signed [SC_W-1:0] s_lat, s_lon, c_la, c_lb;

  hgcd_rot_cordic #(.STEPS(CORDIC_STEPS)) u_rot_dlat (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(half_vld_r), .in_ang(hlat_ang_r),
    .out_valid(sc_vld), .out_sin(s_lat), .out_cos()
  );
  hgcd_rot_cordic #(.STEPS(CORDIC_STEPS)) u_rot_dlon (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(half_vld_r), .in_ang(hlon_ang_r),
    .out_valid(), .out_sin(s_lon), .out_cos()
  );
  hgcd_rot_cordic #(.STEPS(CORDIC_STEPS)) u_rot_la (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(half_vld_r), .in_ang(la2_r),
    .out_valid(), .out_sin(), .out_cos(c_la)
  );
  hgcd_rot_cordic #(.STEPS(CORDIC_STEPS)) u_rot_lb (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(half_vld_r), .in_ang(lb2_r),
    .out_valid(), .out_sin(), .out_cos(c_lb)
  );

  // stage: squares and cosine product
  logic                   m1_vld_r;
  logic signed [SC_W-1:0] hlat_r, hlon_r, cc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
    end else if (en) begin
      m1_vld_r <= sc_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hlat_r <= mul_q30(s_lat, s_lat);
      hlon_r <= mul_q30(s_lon, s_lon);
      cc_r   <= mul_q30(c_la, c_lb);
    end
  end

  // stage: cos*cos*sin^2(dlon/2)
  logic                   m2_vld_r;
  logic signed [SC_W-1:0] hlat2_r, t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_vld_r <= 1'b0;
    end else if (en) begin
      m2_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hlat2_r <= hlat_r;
      t_r     <= mul_q30(cc_r, hlon_r);
    end
  end

  // stage: a, clamped to [0, 1]
  logic                   a_vld_r;
  logic [ROOT_W-1:0]      a_r, na_r;
  logic signed [SC_W:0]   a_sum;
  logic [ROOT_W-1:0]      a_clamp;

  assign a_sum = (SC_W+1)'(hlat2_r) + (SC_W+1)'(t_r);

  always_comb begin
    priority if (a_sum < 0) begin
      a_clamp = '0;
    end else if (a_sum > signed'((SC_W+1)'(ONE_Q30))) begin
      a_clamp = ONE_Q30;
    end else begin
      a_clamp = a_sum[ROOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= m2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r  <= a_clamp;
      na_r <= ONE_Q30 - a_clamp;
    end
  end

  // square roots
  logic              rt_vld;
  logic [ROOT_W-1:0] root_a, root_na;

  hgcd_sqrt u_sqrt_a (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(a_vld_r), .in_val(a_r),
    .out_valid(rt_vld), .out_root(root_a)
  );
  hgcd_sqrt u_sqrt_na (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(a_vld_r), .in_val(na_r),
    .out_valid(), .out_root(root_na)
  );

  // central half angle
  logic             ang_vld;
  logic [ANG_W-1:0] ang;

  hgcd_vec_cordic #(.STEPS(CORDIC_STEPS)) u_vec (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(rt_vld), .in_x(root_na), .in_y(root_a),
    .out_valid(ang_vld), .out_ang(ang)
  );

  // stage: angle times radius
  logic                        p_vld_r;
  logic [ANG_W+RADIUS_W-1:0]   p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (en) begin
      p_vld_r <= ang_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= (ANG_W+RADIUS_W)'(ang) * (ANG_W+RADIUS_W)'(radius_r);
    end
  end

  // output stage: *125, round, saturate
  localparam int unsigned MM_W = ANG_W + RADIUS_W + 8;
  logic [MM_W-1:0]   mm_full;
  logic [DIST_W:0]   mm;
  logic [DIST_W-1:0] dist_r;

  assign mm_full = MM_W'(p_r) * MM_W'(125) + (MM_W'(1) << 25);
  assign mm      = mm_full[DIST_W+26:26];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= mm[DIST_W] ? {DIST_W{1'b1}} : mm[DIST_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_distance_mm = dist_r;

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");
  a_clamp_range: assert property (@(posedge clk) disable iff (!rst_n)
    a_vld_r |-> (a_r <= ONE_Q30) && (32'(a_r) + 32'(na_r) == 32'(ONE_Q30)))
    else $error("haversine term out of range");
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    ang_vld |-> ang < 31'd1873000000)
    else $error("central angle out of range");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (p_vld_r && !en) |=> p_vld_r && $stable(p_r))
    else $error("pipeline moved during stall");
`endif

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Great-circle distance block: a directed table of coordinate pairs, then
// random pairs under several radius settings and handshake idling patterns.
// Every distance is checked against a fixed-point haversine model in order.
// ----------------------------------------------------------------------------
module testbench;
  import hgcd_pkg::*;

  localparam int unsigned STEPS      = 28;
  localparam int unsigned DRAIN_CYC  = 2 * STEPS + 41 + 30;
  localparam int unsigned WATCH_LIM  = 5000;
  localparam int unsigned HOLD_CYC   = 400;
  localparam int unsigned PHASE_ITEMS = 275;
  localparam longint PI_Q        = 64'd3373259426;
  localparam longint HALF_PI_Q   = 64'd1686629713;
  localparam longint INV_GAIN_Q  = 64'd652032874;
  localparam longint ONE_Q       = 64'd1073741824;
  localparam longint unsigned RAD_K = 64'd2012227627;
  localparam longint unsigned DMAX  = 64'h7FFFFFFFF;
  localparam longint ATAN_TBL [0:30] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
    131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
    128, 64, 32, 16, 8, 4, 2, 1};

  typedef struct {
    logic signed [30:0] lat_a;
    logic signed [31:0] lon_a;
    logic signed [30:0] lat_b;
    logic signed [31:0] lon_b;
  } coord_pair_t;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [RADIUS_W-1:0] cfg_earth_radius_m;
  logic in_valid;
  logic in_ready;
  logic signed [30:0] in_lat_a;
  logic signed [31:0] in_lon_a;
  logic signed [30:0] in_lat_b;
  logic signed [31:0] in_lon_b;
  logic out_valid;
  logic out_ready;
  logic [DIST_W-1:0] out_distance_mm;

  haversine_great_circle_distance_top #(.CORDIC_STEPS(STEPS)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_earth_radius_m(cfg_earth_radius_m),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_lat_a(in_lat_a), .in_lon_a(in_lon_a), .in_lat_b(in_lat_b), .in_lon_b(in_lon_b),
    .out_valid(out_valid), .out_ready(out_ready), .out_distance_mm(out_distance_mm)
  );

  logic [DIST_W-1:0] dist_expected_q[$];
  logic [RADIUS_W-1:0] radius_m;
  int idle_mode;        // 0: sender light, 1: sender heavy, 2: none
  bit hold_req;
  int mismatches;
  int n_items;
  int n_dists;
  // handshakes sampled mid-cycle, seen at the following rising edge
  bit in_fire, out_fire, cfg_fire;
  logic [DIST_W-1:0] out_dist_s;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    in_fire    = in_valid && in_ready;
    out_fire   = out_valid && out_ready;
    cfg_fire   = cfg_valid && cfg_ready;
    out_dist_s = out_distance_mm;
  end

  // ---------------- fixed-point haversine model ----------------
  function automatic longint deg_to_rad(input longint d);
    longint unsigned mag;
    longint r;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    r = longint'((mag * RAD_K + (64'd1 << 29)) >> 30);
    return (d < 0) ? -r : r;
  endfunction

  function automatic longint qmul(input longint p, input longint q);
    longint unsigned mp, mq;
    longint r;
    mp = (p < 0) ? -p : p;
    mq = (q < 0) ? -q : q;
    r = longint'((mp * mq + (64'd1 << 29)) >> 30);
    return ((p < 0) != (q < 0)) ? -r : r;
  endfunction

  function automatic void rot_sin_cos(input longint ang, output longint s, output longint c);
    bit neg, flip;
    longint x, y, z, dx, dy;
    neg = ang < 0;
    flip = 0;
    z = neg ? -ang : ang;
    x = INV_GAIN_Q;
    y = 0;
    if (z > HALF_PI_Q) begin
      z = PI_Q - z;
      flip = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TBL[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TBL[i];
      end
    end
    s = neg ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint central_angle(input longint x, input longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_TBL[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_TBL[i];
      end
    end
    return (z < 0) ? 0 : z;
  endfunction

  function automatic logic [DIST_W-1:0] great_circle_mm(input coord_pair_t cp,
                                                         input logic [RADIUS_W-1:0] rad);
    longint la, oa, lb, ob, s, c, ca, cb, hlat, hlon, a, ang;
    longint unsigned mm;
    la = deg_to_rad(longint'(cp.lat_a));
    oa = deg_to_rad(longint'(cp.lon_a));
    lb = deg_to_rad(longint'(cp.lat_b));
    ob = deg_to_rad(longint'(cp.lon_b));
    rot_sin_cos((lb - la) >>> 1, s, c);
    hlat = qmul(s, s);
    rot_sin_cos((ob - oa) >>> 1, s, c);
    hlon = qmul(s, s);
    rot_sin_cos(la, s, ca);
    rot_sin_cos(lb, s, cb);
    a = hlat + qmul(qmul(ca, cb), hlon);
    if (a < 0) a = 0;
    if (a > ONE_Q) a = ONE_Q;
    ang = central_angle(longint'(int_sqrt((ONE_Q - a) << 30)), longint'(int_sqrt(a << 30)));
    mm = ((longint'(ang) * longint'(rad)) * 125 + (64'd1 << 25)) >> 26;
    if (mm > DMAX) mm = DMAX;
    return mm[DIST_W-1:0];
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic coord_pair_t pair(input longint la, input longint oa,
                                       input longint lb, input longint ob);
    coord_pair_t cp;
    cp.lat_a = la[30:0];
    cp.lon_a = oa[31:0];
    cp.lat_b = lb[30:0];
    cp.lon_b = ob[31:0];
    return cp;
  endfunction

  function automatic longint rand_in(input longint lim);
    return longint'($urandom_range(2 * lim)) - lim;
  endfunction

  function automatic coord_pair_t rand_pair();
    coord_pair_t cp;
    int kind;
    kind = $urandom_range(99);
    if (kind < 70) begin
      cp = pair(rand_in(900000000), rand_in(1800000000),
                rand_in(900000000), rand_in(1800000000));
    end else if (kind < 85) begin
      // any bit pattern, far outside the earth's ranges too
      cp.lat_a = 31'($urandom);
      cp.lon_a = $urandom;
      cp.lat_b = 31'($urandom);
      cp.lon_b = $urandom;
    end else if (kind < 93) begin
      // nearby points
      cp = pair(rand_in(900000000), rand_in(1800000000), 0, 0);
      cp.lat_b = cp.lat_a + 31'(rand_in(1000));
      cp.lon_b = cp.lon_a + 32'(rand_in(1000));
    end else begin
      // near antipodal
      cp = pair(rand_in(900000000), rand_in(1800000000), 0, 0);
      cp.lat_b = -cp.lat_a + 31'(rand_in(50));
      cp.lon_b = cp.lon_a + ((cp.lon_a < 0) ? 32'sd1800000000 : -32'sd1800000000)
                 + 32'(rand_in(50));
    end
    return cp;
  endfunction

  task automatic send_pair(input coord_pair_t cp, input bit zero_exp);
    int pct;
    pct = (idle_mode == 0) ? 22 : (idle_mode == 1) ? 48 : 0;
    while ($urandom_range(99) < pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_lat_a <= cp.lat_a;
    in_lon_a <= cp.lon_a;
    in_lat_b <= cp.lat_b;
    in_lon_b <= cp.lon_b;
    do @(posedge clk); while (!in_fire);
    dist_expected_q.push_back(zero_exp ? '0 : great_circle_mm(cp, radius_m));
    n_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (dist_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_radius(input logic [RADIUS_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_earth_radius_m <= v;
    do @(posedge clk); while (!cfg_fire);
    radius_m = v;
    cfg_valid <= 1'b0;
  endtask

  // ---------------- receiver ----------------
  always @(posedge clk) begin : recv_ctl
    int hold_left;
    int pct;
    if (hold_req) begin
      hold_left = HOLD_CYC;
      hold_req = 0;
    end
    pct = (idle_mode == 0) ? 48 : (idle_mode == 1) ? 22 : 0;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= pct);
    end
  end

  always @(posedge clk) begin
    if (out_fire) begin
      if (dist_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected distance %0d", out_dist_s);
      end else begin
        logic [DIST_W-1:0] e;
        e = dist_expected_q.pop_front();
        n_dists++;
        if (e !== out_dist_s) begin
          mismatches++;
          if (mismatches <= 10)
            $display("distance mismatch: expected %0d got %0d", e, out_dist_s);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int quiet;
    if (in_fire || out_fire || cfg_fire) quiet = 0;
    else quiet++;
    if (quiet >= WATCH_LIM) begin
      $display("timeout: no handshake for %0d cycles", quiet);
      $display("haversine_great_circle_distance_top: mismatch");
      $finish;
    end
  end

  // ---------------- main sequence ----------------
  initial begin
    coord_pair_t dir_tbl[$];
    logic [RADIUS_W-1:0] phase_radius [0:5];
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_earth_radius_m = '0;
    in_valid = 1'b0;
    in_lat_a = '0;
    in_lon_a = '0;
    in_lat_b = '0;
    in_lon_b = '0;
    out_ready = 1'b0;
    idle_mode = 2;
    hold_req = 0;
    mismatches = 0;
    n_items = 0;
    n_dists = 0;
    radius_m = RADIUS_RESET;
    phase_radius = '{23'd6300000, 23'd6400000, 23'd0, 23'h7FFFFF, 23'd6371001, 23'd1};

    dir_tbl.push_back(pair(0, 0, 0, 0));
    dir_tbl.push_back(pair(900000000, 1800000000, 900000000, 1800000000));
    dir_tbl.push_back(pair(900000000, 0, -900000000, 0));          // pole to pole
    dir_tbl.push_back(pair(0, 0, 0, 1800000000));                  // antipodal on equator
    dir_tbl.push_back(pair(0, -1800000000, 0, 1800000000));        // same point, wrapped
    dir_tbl.push_back(pair(-900000000, -1800000000, 900000000, 1800000000));
    dir_tbl.push_back(pair(0, 0, 1, 0));                           // one unit apart
    dir_tbl.push_back(pair(0, 0, 0, 10000000));                    // one degree of longitude
    dir_tbl.push_back(pair(450000000, 900000000, -450000000, -900000000));
    dir_tbl.push_back(pair(1073741823, 2147483647, -1073741824, -64'sd2147483648));
    dir_tbl.push_back(pair(-1073741824, -64'sd2147483648, -1073741824, -64'sd2147483648));
    dir_tbl.push_back(pair(1073741823, 0, 0, 2147483647));
    dir_tbl.push_back(pair(-1, -1, 0, 0));
    dir_tbl.push_back(pair(515000000, -1200000, 407000000, -740000000));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[i]) send_pair(dir_tbl[i], 1'b0);
    drain();
    // zero radius: every distance is zero
    write_radius('0);
    foreach (dir_tbl[i]) send_pair(dir_tbl[i], 1'b1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_radius(phase_radius[ph]);
      idle_mode = ph / 2;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 1 && k == 40) hold_req = 1;
        send_pair(rand_pair(), 1'b0);
      end
      drain();
    end

    $display("covered %0d coordinate pairs, %0d distances checked, radius 0 to max",
             n_items, n_dists);
    $display("handshake idling on both sides, one long receiver stall");
    if (mismatches == 0)
      $display("haversine_great_circle_distance_top: match");
    else
      $display("haversine_great_circle_distance_top: mismatch");
    $finish;
  end

endmodule
